@@ sv/sgbp_pkg.sv @@
package sgbp_pkg;

    // Code layout: unary quotient, terminating zero, sign bit, remainder
    localparam int REM_BITS  = 8;
    localparam int TAIL_BITS = REM_BITS + 2;
    localparam int DIV_W     = 9;
    localparam int SAMPLE_W  = 16;
    localparam int BYTE_W    = 8;
    localparam int FILL_W    = 3;
    localparam int TAKE_W    = 4;
    localparam int CNT_W     = 4;
    localparam int REM_W     = SAMPLE_W + 1;

    localparam logic [DIV_W-1:0]  DIV_RESET   = 9'd255;
    localparam logic [DIV_W-1:0]  DIV_MIN     = 9'd128;
    localparam logic [DIV_W-1:0]  DIV_MAX     = 9'd256;
    localparam logic [CNT_W-1:0]  DIV_LAST_IX = 4'd8;
    localparam logic [TAKE_W-1:0] BYTE_BITS   = 4'd8;
    localparam logic [TAKE_W-1:0] TAIL_LEN    = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ONES,
        ST_TAIL,
        ST_FLUSH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic ones_step;
        logic tail_step;
        logic pad_emit;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_last;
        logic ones_zero;
        logic ones_stall;
        logic tail_final;
        logic tail_stall;
        logic fill_zero;
        logic out_free;
        logic flush;
    } stat_t;

endpackage

@@ sv/signed_golomb_bit_packer_unit.sv @@
// Channel  | Ports                          | Payload
// ---------+--------------------------------+------------------------------------
// input    | s_tvalid s_tready s_tdata      | s_tdata[15:0] sample; s_tlast flush
//          | s_tlast                        |
// output   | m_tvalid m_tready m_tdata      | m_tdata[7:0] out_byte; m_tlast last
//          | m_tlast                        |
// config   | cfg_wr_en cfg_wr_data          | cfg_wr_data[8:0] divisor
//
// One sample at a time: acceptance in idle, the restoring divider, the unary ones
// placed in byte-sized runs (up to 256 ones), then the zero, sign and remainder,
// and a flush step that pads the partial byte when s_tlast was set.
// The partial byte persists across samples; reset clears it and sets divisor 255.
// A byte that cannot enter the output register stalls the packer in place.
module signed_golomb_bit_packer_unit #(
    parameter logic [sgbp_pkg::DIV_W-1:0] DIVISOR_RESET = sgbp_pkg::DIV_RESET
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [sgbp_pkg::DIV_W-1:0]           cfg_wr_data,  // [8:0] divisor
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic signed [sgbp_pkg::SAMPLE_W-1:0] s_tdata,      // [15:0] sample
    input  logic                                 s_tlast,      // flush
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sgbp_pkg::BYTE_W-1:0]          m_tdata,      // [7:0] out_byte
    output logic                                 m_tlast       // last
);
    import sgbp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sgbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sgbp_dpath #(
        .DIVISOR_RESET (DIVISOR_RESET)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .stat        (stat)
    );

    // At most one datapath operation per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // No work goes on while the packer is ready for a new sample
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(cmd.div_step || cmd.ones_step || cmd.tail_step || cmd.pad_emit))
        else $error("datapath busy while idle");

    // Padding only with bits pending and room in the output register
    a_pad_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pad_emit |-> (!stat.fill_zero && stat.out_free))
        else $error("pad byte without pending bits or output room");

    // Without flush the last tail chunk returns straight to idle
    a_tail_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tail_step && stat.tail_final && !stat.flush) |=> s_tready)
        else $error("packer did not return to idle after the tail");

endmodule

@@ sv/sgbp_ctrl.sv @@
module sgbp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  sgbp_pkg::stat_t stat,
    output sgbp_pkg::cmd_t  cmd
);
    import sgbp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_ONES;
                end
            end
            ST_ONES: begin
                if (stat.ones_zero) begin
                    state_next = ST_TAIL;
                end else if (!stat.ones_stall) begin
                    cmd.ones_step = 1'b1;
                end
            end
            ST_TAIL: begin
                if (!stat.tail_stall) begin
                    cmd.tail_step = 1'b1;
                    if (stat.tail_final) begin
                        state_next = stat.flush ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                // pad the partial byte, if any, and mark it last
                if (stat.fill_zero) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.pad_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/sgbp_dpath.sv @@
module sgbp_dpath #(
    parameter logic [sgbp_pkg::DIV_W-1:0] DIVISOR_RESET = sgbp_pkg::DIV_RESET
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sgbp_pkg::DIV_W-1:0]         cfg_wr_data,
    input  logic signed [sgbp_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sgbp_pkg::BYTE_W-1:0]        m_tdata,
    output logic                               m_tlast,
    input  sgbp_pkg::cmd_t                     cmd,
    output sgbp_pkg::stat_t                    stat
);
    import sgbp_pkg::*;

    logic [DIV_W-1:0]     divisor_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     dsh_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_W-1:0]     q_reg;
    logic [TAIL_BITS-1:0] tail_reg;
    logic [TAKE_W-1:0]    tail_left_reg;
    logic [BYTE_W-1:0]    pend_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic                 flush_reg;
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_data_reg;
    logic                 out_last_reg;

    logic [DIV_W-1:0]     div_clamped;
    logic [SAMPLE_W-1:0]  mag;
    logic                 ge;
    logic [REM_W-1:0]     rem_next;
    logic [TAKE_W-1:0]    space;
    logic [TAKE_W-1:0]    take_ones;
    logic [TAKE_W-1:0]    take_tail;
    logic [TAKE_W-1:0]    take;
    logic [BYTE_W-1:0]    top_mask;
    logic [BYTE_W-1:0]    chunk;
    logic [BYTE_W-1:0]    merged;
    logic [TAKE_W-1:0]    fill_sum;
    logic                 full;
    logic                 out_free;
    logic                 step;
    logic                 emit;

    // Divisor clamped to 128..256
    always_comb begin
        if (divisor_reg[8:7] == 2'b00) begin
            div_clamped = DIV_MIN;
        end else if (divisor_reg[8] && (divisor_reg[7:0] != '0)) begin
            div_clamped = DIV_MAX;
        end else begin
            div_clamped = divisor_reg;
        end
    end

    // Sample magnitude; the most negative sample maps to 32768
    assign mag = s_tdata[SAMPLE_W-1] ? (~s_tdata + 1'b1) : s_tdata;

    // Restoring divide step, one quotient bit a cycle
    assign ge       = (rem_reg >= dsh_reg);
    assign rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;

    // Bits to place this cycle: free room in the byte, or what is left
    assign space     = BYTE_BITS - {1'b0, fill_reg};
    assign take_ones = (q_reg >= {{(DIV_W-TAKE_W){1'b0}}, space}) ? space : q_reg[TAKE_W-1:0];
    assign take_tail = (tail_left_reg >= space) ? space : tail_left_reg;
    assign take      = cmd.tail_step ? take_tail : take_ones;
    assign top_mask  = ~(8'hFF >> take);
    assign chunk     = cmd.tail_step ? (tail_reg[TAIL_BITS-1 -: BYTE_W] & top_mask) : top_mask;
    assign merged    = pend_reg | (chunk >> fill_reg);
    assign fill_sum  = {1'b0, fill_reg} + take;
    assign full      = fill_sum[TAKE_W-1];

    assign out_free = !out_valid_reg || m_tready;
    assign step     = cmd.ones_step || cmd.tail_step;
    assign emit     = step && full;

    // Status to controller
    always_comb begin
        stat            = '0;
        stat.div_last   = (cnt_reg == '0);
        stat.ones_zero  = (q_reg == '0);
        stat.ones_stall = (take_ones == space) && !out_free;
        stat.tail_final = (tail_left_reg <= space);
        stat.tail_stall = (take_tail == space) && !out_free;
        stat.fill_zero  = (fill_reg == '0);
        stat.out_free   = out_free;
        stat.flush      = flush_reg;
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= DIVISOR_RESET;
        end else if (cfg_wr_en) begin
            divisor_reg <= cfg_wr_data;
        end
    end

    // Divider, quotient count-down and tail shifter
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg       <= {1'b0, mag};
            dsh_reg       <= {div_clamped, {REM_BITS{1'b0}}};
            cnt_reg       <= DIV_LAST_IX;
            q_reg         <= '0;
            tail_reg      <= {1'b0, s_tdata[SAMPLE_W-1], {REM_BITS{1'b0}}};
            tail_left_reg <= TAIL_LEN;
            flush_reg     <= s_tlast;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_next;
            dsh_reg  <= dsh_reg >> 1;
            cnt_reg  <= cnt_reg - 1'b1;
            q_reg    <= {q_reg[DIV_W-2:0], ge};
            if (cnt_reg == '0) begin
                tail_reg[REM_BITS-1:0] <= rem_next[REM_BITS-1:0];
            end
        end else if (cmd.ones_step) begin
            q_reg <= q_reg - {{(DIV_W-TAKE_W){1'b0}}, take};
        end else if (cmd.tail_step) begin
            tail_reg      <= tail_reg << take;
            tail_left_reg <= tail_left_reg - take;
        end
    end

    // Partial byte, kept across items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            fill_reg <= '0;
        end else if (cmd.pad_emit || emit) begin
            pend_reg <= '0;
            fill_reg <= '0;
        end else if (step) begin
            pend_reg <= merged;
            fill_reg <= fill_sum[FILL_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit || cmd.pad_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= merged;
            out_last_reg <= flush_reg && cmd.tail_step && stat.tail_final;
        end else if (cmd.pad_emit) begin
            out_data_reg <= pend_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import sgbp_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RAND_PER_PHASE = 40;
    localparam int NUM_PHASES     = 9;
    localparam int IDLE_PCT       = 19;
    localparam int SETTLE_CYCLES  = 50;

    // One code byte as it leaves the packer
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } code_byte_t;

    // Directed stimulus row; n_typed > 0 means the bytes are given here
    typedef struct packed {
        logic [15:0] sample;
        logic        flush;
        logic [1:0]  n_typed;
        logic [7:0]  b0;
        logic        l0;
        logic [7:0]  b1;
        logic        l1;
    } dir_row_t;

    // Divisor setting per phase; phase 0 keeps the reset value
    localparam logic [8:0] DIV_PLAN [0:NUM_PHASES-1] = '{
        9'd255, 9'd128, 9'd256, 9'd0, 9'd511, 9'd127, 9'd257, 9'd0, 9'd0
    };

    // Directed rows, all run with divisor 255; the typed rows start from an empty bit stream
    localparam dir_row_t DIR_TAB [0:19] = '{
        '{16'h0000, 1'b1, 2'd2, 8'h00, 1'b0, 8'h00, 1'b1},  // zero sample, pad byte
        '{16'hFFFF, 1'b1, 2'd2, 8'h40, 1'b0, 8'h40, 1'b1},  // -1, sign set
        '{16'h0001, 1'b1, 2'd2, 8'h00, 1'b0, 8'h40, 1'b1},  // +1
        '{16'h00FF, 1'b1, 2'd2, 8'h80, 1'b0, 8'h00, 1'b1},  // one unary one
        '{16'hFF01, 1'b1, 2'd2, 8'hA0, 1'b0, 8'h00, 1'b1},  // -255
        '{16'h05FA, 1'b1, 2'd2, 8'hFC, 1'b0, 8'h00, 1'b1},  // 1530: ends on byte boundary
        '{16'hFA06, 1'b1, 2'd2, 8'hFD, 1'b0, 8'h00, 1'b1},  // -1530: same, negative
        '{16'h7FFF, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},  // largest positive
        '{16'h8000, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},  // most negative
        '{16'h8001, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{16'h0000, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{16'h00FE, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},  // largest remainder
        '{16'hFF02, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{16'h0100, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{16'h3039, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{16'hCFC7, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{16'h7FFF, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{16'h8000, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{16'h5555, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{16'hAAAA, 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0}
    };

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [DIV_W-1:0] cfg_wr_data = '0;   // [8:0] divisor
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata     = '0;   // [15:0] sample
    logic             s_tlast     = 1'b0; // flush
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [7:0]       m_tdata;            // [7:0] out_byte
    logic             m_tlast;            // last

    // Predictor state
    logic [8:0] divisor_q = DIV_RESET;
    logic [7:0] acc_byte  = '0;
    int         acc_fill  = 0;

    code_byte_t new_codes[$];
    code_byte_t codes_due[$];
    int         errors    = 0;
    int         cycle_cnt = 0;
    bit         calm      = 1'b0;

    signed_golomb_bit_packer_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Divisor as the packer uses it, clamped to its legal range
    function automatic logic [8:0] eff_divisor();
        if (divisor_q < DIV_MIN) begin
            return DIV_MIN;
        end
        if (divisor_q > DIV_MAX) begin
            return DIV_MAX;
        end
        return divisor_q;
    endfunction

    // Append one bit, MSB first; a full byte goes out unmarked
    function automatic void shift_bit(input logic b);
        acc_byte[7 - acc_fill] = b;
        acc_fill++;
        if (acc_fill == 8) begin
            new_codes.insert(new_codes.size(), code_byte_t'{acc_byte, 1'b0});
            acc_byte = '0;
            acc_fill = 0;
        end
    endfunction

    // Code one sample into new_codes: unary quotient, zero, sign, remainder
    function automatic void pack_sample(input logic [15:0] raw, input logic flsh);
        logic        neg;
        logic [16:0] mag;
        logic [16:0] quo;
        logic [16:0] rem;
        logic [8:0]  d;
        int          k;
        new_codes.delete();
        neg = raw[15];
        mag = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        d   = eff_divisor();
        quo = mag / {8'd0, d};
        rem = mag % {8'd0, d};
        for (k = 0; k < int'(quo); k++) begin
            shift_bit(1'b1);
        end
        shift_bit(1'b0);
        shift_bit(neg);
        for (k = REM_BITS - 1; k >= 0; k--) begin
            shift_bit(rem[k]);
        end
        if (flsh) begin
            if (acc_fill != 0) begin
                new_codes.insert(new_codes.size(), code_byte_t'{acc_byte, 1'b1});
                acc_byte = '0;
                acc_fill = 0;
            end else if (new_codes.size() > 0) begin
                // stream ended on a byte boundary: mark the last full byte
                new_codes[new_codes.size() - 1].last = 1'b1;
            end
        end
    endfunction

    // Random sample: extremes, small magnitudes, near multiples of the divisor, anything
    function automatic logic [15:0] pick_sample();
        logic [16:0] mag;
        logic [8:0]  d;
        d = eff_divisor();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'h8001;
                endcase
            end
            1, 2, 3: begin
                mag = 17'($urandom_range(600));
            end
            4, 5: begin
                mag = 17'($urandom_range(127) * d + ($urandom_range(1) ? 0 : d - 1));
            end
            default: begin
                return 16'($urandom);
            end
        endcase
        return $urandom_range(1) ? (16'h0000 - mag[15:0]) : mag[15:0];
    endfunction

    // Offer one sample, predict at the transfer, then maybe leave a gap
    task automatic push_sample(input dir_row_t row);
        s_tvalid <= 1'b1;
        s_tdata  <= row.sample;
        s_tlast  <= row.flush;
        do @(posedge aclk); while (!s_tready);
        pack_sample(row.sample, row.flush);
        if (row.n_typed == 2'd0) begin
            foreach (new_codes[i]) begin
                codes_due.insert(codes_due.size(), new_codes[i]);
            end
        end else begin
            codes_due.insert(codes_due.size(), code_byte_t'{row.b0, row.l0});
            if (row.n_typed == 2'd2) begin
                codes_due.insert(codes_due.size(), code_byte_t'{row.b1, row.l1});
            end
        end
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge aclk);
        end
    endtask

    // Result side back-pressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare every output transfer with the oldest predicted byte
    always @(posedge aclk) begin : out_check
        code_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (codes_due.size() == 0) begin
                $display("%0t: unexpected transfer: out_byte %02h last %0b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = codes_due.pop_front();
                if (m_tdata !== want.out_byte) begin
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, want.out_byte, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d bytes still expected", $time, codes_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus: directed rows, then random samples over a series of divisors
    initial begin
        dir_row_t   row;
        logic [8:0] div_val;
        int         ph;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                // divisor changes only with the packer drained
                s_tvalid <= 1'b0;
                while (codes_due.size() != 0) @(posedge aclk);
                repeat (SETTLE_CYCLES) @(posedge aclk);
                case (ph)
                    7:       div_val = 9'($urandom_range(511));
                    8:       div_val = 9'($urandom_range(256, 128));
                    default: div_val = DIV_PLAN[ph];
                endcase
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= div_val;
                @(posedge aclk);
                cfg_wr_en   <= 1'b0;
                divisor_q    = div_val;
            end
            // one phase runs with no idling on either side
            calm = (ph == 2);
            if (ph == 0) begin
                foreach (DIR_TAB[i]) begin
                    push_sample(DIR_TAB[i]);
                end
            end
            repeat (RAND_PER_PHASE) begin
                row        = '0;
                row.sample = pick_sample();
                row.flush  = ($urandom_range(3) == 0);
                push_sample(row);
            end
        end
        s_tvalid <= 1'b0;
        while (codes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
